// ===== src/paren_add_sub_evaluator_defines.svh =====
// Assertion macros shared by the evaluator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PAREN_ADD_SUB_EVALUATOR_DEFINES_SVH
`define PAREN_ADD_SUB_EVALUATOR_DEFINES_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define PASE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
// Condition must never be true outside reset.
`define PASE_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define PASE_ASSERT(lbl, clk, rst_n, prop)
`define PASE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/pase_pkg.sv =====
// Types and constants for the parenthesized add/subtract evaluator.
// No dependencies; used by pase_cell and paren_add_sub_evaluator.
`default_nettype none
package pase_pkg;

	localparam int OUT_VALUE_W = 32;
	localparam int STATUS_W    = 2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNMATCHED  = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_beat_t;

	typedef struct packed {
		logic signed [OUT_VALUE_W-1:0] value;
		logic [STATUS_W-1:0]           status;
	} out_beat_t;

	// Shift command broadcast to every stack cell.
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

endpackage
`default_nettype wire

// ===== src/pase_cell.sv =====
// One entry of the shifting nesting stack: holds a saved (sign, total) pair.
// Depends on pase_pkg for the shift command struct.
`default_nettype none
module pase_cell #(
	parameter int W = 33
) (
	input  wire                  clk,
	input  wire pase_pkg::stk_ctl_t ctl,
	input  wire [W-1:0]          from_above,
	input  wire [W-1:0]          from_below,
	output logic [W-1:0]         entry
);

	logic [W-1:0] entry_q;

	// Push takes the neighbor nearer the top, pop takes the one below.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= from_above;
		end else if (ctl.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// ===== src/paren_add_sub_evaluator.sv =====
// A final character's state is registered in the finished stage, then in the output register.
// One character per cycle while in_stall is low; every step is one update of the state
// registers, and the nesting stack is a row of cells that shift one place per push or pop.
// Reset clears total, operand, sign, nesting depth, error and the valid flags of both
// output stages; stack cells hold no reset and are read only below the nesting depth.
`default_nettype none
`include "paren_add_sub_evaluator_defines.svh"
module paren_add_sub_evaluator #(
	parameter int NEST_DEPTH = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire pase_pkg::in_beat_t in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output pase_pkg::out_beat_t  out_data
);

	localparam int PW = $clog2(NEST_DEPTH + 1);
	localparam int EW = VALUE_BITS + 1;

	// Expression state.
	logic [VALUE_BITS-1:0] total_q, acc_q;
	logic                  sign_q;
	logic [PW-1:0]         ptr_q;
	logic [pase_pkg::STATUS_W-1:0] err_q;

	// Finished-expression stage and output register.
	logic                  valid_s1;
	logic [VALUE_BITS-1:0] total_s1, acc_s1;
	logic                  sign_s1;
	logic [pase_pkg::STATUS_W-1:0] err_s1;
	logic                  out_valid_q;
	pase_pkg::out_beat_t   out_data_q;

	logic in_acc, out_move, s1_move;
	logic is_digit, is_plus, is_minus, is_open, is_close, can_push, can_pop;
	logic [3:0]            digit;
	logic [VALUE_BITS-1:0] signed_acc, fold, close_total, top_val;
	logic                  top_sign;
	logic [VALUE_BITS-1:0] nxt_total, nxt_acc;
	logic                  nxt_sign;
	logic [PW-1:0]         nxt_ptr;
	logic [pase_pkg::STATUS_W-1:0] nxt_err;
	logic [VALUE_BITS-1:0] fin_sum;
	logic [pase_pkg::OUT_VALUE_W-1:0] res_value;

	pase_pkg::stk_ctl_t stk_ctl;
	logic [EW-1:0] cell_q [NEST_DEPTH];

	// Handshakes: the output register drains, the final stage feeds it, and
	// input stalls only while a finished expression cannot advance.
	assign out_move = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && out_move;
	assign in_stall = valid_s1 && !out_move;
	assign in_acc   = in_valid && !in_stall;

	// Classify the character.
	assign is_digit = (in_data.char_code >= pase_pkg::CH_ZERO) &&
		(in_data.char_code <= pase_pkg::CH_NINE);
	assign is_plus  = in_data.char_code == pase_pkg::CH_PLUS;
	assign is_minus = in_data.char_code == pase_pkg::CH_MINUS;
	assign is_open  = in_data.char_code == pase_pkg::CH_OPEN;
	assign is_close = in_data.char_code == pase_pkg::CH_CLOSE;
	assign digit    = 4'(in_data.char_code - pase_pkg::CH_ZERO);
	assign can_push = ptr_q < PW'(NEST_DEPTH);
	assign can_pop  = ptr_q != '0;

	// Top of stack sits in cell 0.
	assign top_sign = cell_q[0][EW-1];
	assign top_val  = cell_q[0][VALUE_BITS-1:0];

	assign signed_acc  = sign_q ? (VALUE_BITS'(0) - acc_q) : acc_q;
	assign fold        = total_q + signed_acc;
	assign close_total = !can_pop ? fold :
		(top_sign ? (top_val - fold) : (top_val + fold));

	// Next state for one character.
	always_comb begin
		nxt_total = total_q;
		nxt_acc   = acc_q;
		nxt_sign  = sign_q;
		nxt_ptr   = ptr_q;
		nxt_err   = err_q;
		if (is_digit) begin
			nxt_acc = (acc_q << 3) + (acc_q << 1) + VALUE_BITS'(digit);
		end else if (is_plus || is_minus) begin
			nxt_total = fold;
			nxt_sign  = is_minus;
			nxt_acc   = '0;
		end else if (is_open) begin
			// Operand is carried into the parenthesis on purpose.
			nxt_total = '0;
			nxt_sign  = 1'b0;
			if (can_push) begin
				nxt_ptr = ptr_q + PW'(1);
			end else if (err_q == pase_pkg::ST_OK) begin
				nxt_err = pase_pkg::ST_OVERFLOW;
			end
		end else if (is_close) begin
			nxt_total = close_total;
			nxt_acc   = '0;
			if (can_pop) begin
				nxt_ptr = ptr_q - PW'(1);
			end else if (err_q == pase_pkg::ST_OK) begin
				nxt_err = pase_pkg::ST_UNMATCHED;
			end
		end
	end

	// Hold state on idle, advance on a beat, drop back to reset after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			acc_q   <= '0;
			sign_q  <= 1'b0;
			ptr_q   <= '0;
			err_q   <= pase_pkg::ST_OK;
		end else if (in_acc) begin
			if (in_data.is_last) begin
				total_q <= '0;
				acc_q   <= '0;
				sign_q  <= 1'b0;
				ptr_q   <= '0;
				err_q   <= pase_pkg::ST_OK;
			end else begin
				total_q <= nxt_total;
				acc_q   <= nxt_acc;
				sign_q  <= nxt_sign;
				ptr_q   <= nxt_ptr;
				err_q   <= nxt_err;
			end
		end
	end

	// Nesting stack: a row of cells shifting toward the bottom on push.
	assign stk_ctl.push = in_acc && is_open && can_push;
	assign stk_ctl.pop  = in_acc && is_close && can_pop;

	for (genvar i = 0; i < NEST_DEPTH; i++) begin : g_cell
		logic [EW-1:0] above, below;
		if (i == 0) begin : g_top
			assign above = {sign_q, total_q};
		end else begin : g_mid
			assign above = cell_q[i-1];
		end
		if (i == NEST_DEPTH - 1) begin : g_bot
			assign below = '0;
		end else begin : g_up
			assign below = cell_q[i+1];
		end
		pase_cell #(.W(EW)) u_cell (
			.clk        (clk),
			.ctl        (stk_ctl),
			.from_above (above),
			.from_below (below),
			.entry      (cell_q[i])
		);
	end

	// Finished stage: capture the state after the last character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc && in_data.is_last) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.is_last) begin
			total_s1 <= nxt_total;
			acc_s1   <= nxt_acc;
			sign_s1  <= nxt_sign;
			err_s1   <= nxt_err;
		end
	end

	// Final fold of the pending operand, then fit to the 32-bit result field.
	assign fin_sum = total_s1 + (sign_s1 ? (VALUE_BITS'(0) - acc_s1) : acc_s1);

	if (VALUE_BITS >= pase_pkg::OUT_VALUE_W) begin : g_trunc
		assign res_value = fin_sum[pase_pkg::OUT_VALUE_W-1:0];
	end else begin : g_ext
		assign res_value = {{(pase_pkg::OUT_VALUE_W - VALUE_BITS){1'b0}}, fin_sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_data_q.value  <= res_value;
			out_data_q.status <= err_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`PASE_ASSERT(a_ptr_bound, clk, arst_n, ptr_q <= PW'(NEST_DEPTH))
	`PASE_NEVER(a_push_pop, clk, arst_n, stk_ctl.push && stk_ctl.pop)
	`PASE_ASSERT(a_last_clears, clk, arst_n,
		(in_acc && in_data.is_last) |=> (ptr_q == '0 && err_q == pase_pkg::ST_OK))
	`PASE_ASSERT(a_err_sticky, clk, arst_n,
		(err_q != pase_pkg::ST_OK && !(in_acc && in_data.is_last)) |=> $stable(err_q))

endmodule
`default_nettype wire

// ===== tb/tb_paren_add_sub_evaluator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for paren_add_sub_evaluator: streams expression characters,
// predicts each final value and status, and checks the result beats in order.
// Depends on pase_pkg and the evaluator RTL only.
module tb_paren_add_sub_evaluator;
	import pase_pkg::*;

	localparam int NEST_LEVELS    = 16;
	localparam int CLK_HALF       = 5;
	localparam int CYCLE_LIMIT    = 200_000;
	localparam int IDLE_PCT       = 24;
	localparam int BURST_CHARS    = 300;
	localparam int RANDOM_CHARS   = 1500;
	localparam int RANDOM_RESULTS = 60;
	// Idle cycles after the last predicted result has come back, as slack.
	localparam int DRAIN_CYCLES   = 6;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_beat_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_beat_t out_data;

	int          send_idle_pct  = 0;
	int          stall_pct      = 0;
	int unsigned cycle_count    = 0;
	int unsigned mismatch_count = 0;
	int unsigned char_count     = 0;

	// Evaluator shadow state: total, operand, pending sign, saved
	// (total, sign) pairs per open parenthesis, and the sticky status.
	logic [31:0]         acc_total;
	logic [31:0]         acc_operand;
	logic                acc_negative;
	logic [31:0]         paren_total [NEST_LEVELS];
	logic                paren_negative [NEST_LEVELS];
	int unsigned         paren_depth;
	logic [STATUS_W-1:0] acc_status;

	out_beat_t   pending_results[$];
	logic [7:0]  expr_chars[$];

	paren_add_sub_evaluator #(
		.NEST_DEPTH(NEST_LEVELS),
		.VALUE_BITS(32)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #CLK_HALF clk = ~clk;

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver back-pressure: redraw the stall at every falling edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Compare every accepted result beat against the oldest prediction.
	always @(posedge clk) begin : result_check
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: value %0d status %0d",
					out_data.value, out_data.status);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, out_data.value);
					mismatch_count++;
				end
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					mismatch_count++;
				end
			end
		end
	end

	// Return the shadow state to its post-reset values.
	task automatic clear_evaluation();
		acc_total    = '0;
		acc_operand  = '0;
		acc_negative = 1'b0;
		paren_depth  = 0;
		acc_status   = ST_OK;
	endtask

	function automatic logic [31:0] signed_operand();
		return acc_negative ? -acc_operand : acc_operand;
	endfunction

	// Advance the shadow state by one accepted character beat; on the final
	// character queue the expected result and start over.
	task automatic eval_char(input in_beat_t beat);
		logic [7:0] ch;
		out_beat_t  res;
		ch = beat.char_code;
		char_count++;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			acc_operand = acc_operand * 32'd10 + {24'd0, ch - CH_ZERO};
		end else if (ch == CH_PLUS || ch == CH_MINUS) begin
			acc_total    = acc_total + signed_operand();
			acc_negative = (ch == CH_MINUS);
			acc_operand  = '0;
		end else if (ch == CH_OPEN) begin
			// A full stack pushes nothing but still restarts the inner total.
			if (paren_depth < NEST_LEVELS) begin
				paren_total[paren_depth]    = acc_total;
				paren_negative[paren_depth] = acc_negative;
				paren_depth++;
			end else if (acc_status == ST_OK) begin
				acc_status = ST_OVERFLOW;
			end
			// The operand is kept: digits before '(' carry into the group.
			acc_total    = '0;
			acc_negative = 1'b0;
		end else if (ch == CH_CLOSE) begin
			acc_total   = acc_total + signed_operand();
			acc_operand = '0;
			if (paren_depth > 0) begin
				paren_depth--;
				if (paren_negative[paren_depth])
					acc_total = -acc_total;
				acc_total = acc_total + paren_total[paren_depth];
			end else if (acc_status == ST_OK) begin
				acc_status = ST_UNMATCHED;
			end
		end
		if (beat.is_last) begin
			res.value  = acc_total + signed_operand();
			res.status = acc_status;
			pending_results.push_back(res);
			clear_evaluation();
		end
	endtask

	// Drive one character beat. Called at a falling edge, returns at the falling
	// edge after acceptance; valid stays high if the next beat follows at once.
	task automatic send_char(input logic [7:0] ch, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{char_code: ch, is_last: last};
		do @(posedge clk); while (in_stall);
		eval_char(in_data);
		@(negedge clk);
	endtask

	// Send the collected characters as one expression, final beat marked last.
	task automatic send_expression();
		for (int i = 0; i < expr_chars.size(); i++)
			send_char(expr_chars[i], i == expr_chars.size() - 1);
		expr_chars.delete();
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			expr_chars.push_back(text[i]);
		send_expression();
	endtask

	// Hold the sender until every predicted result has come back, then idle a bit.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly short numbers, now and then long enough to wrap 32 bits.
	task automatic add_number();
		int unsigned digits;
		digits = ($urandom_range(15) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
		repeat (digits) expr_chars.push_back(8'(CH_ZERO + $urandom_range(9)));
	endtask

	// Build one random expression: mostly well-formed with random content,
	// some deep enough to overflow the stack, some with stray or missing closes,
	// and some raw byte noise.
	task automatic build_expression();
		int unsigned mode, depth, max_depth, pick, opens;
		logic noise, deep, broken;
		mode   = $urandom_range(99);
		noise  = (mode < 8);
		deep   = (mode >= 8 && mode < 16);
		broken = (mode >= 16 && mode < 24);
		if (noise) begin
			repeat ($urandom_range(1, 12)) expr_chars.push_back(8'($urandom_range(255)));
		end else begin
			depth     = 0;
			max_depth = deep ? NEST_LEVELS + 4 : $urandom_range(1, 6);
			// Deep ones start by nesting close to, up to, or past the stack limit.
			if (deep) begin
				opens = $urandom_range(NEST_LEVELS - 2, NEST_LEVELS + 3);
				repeat (opens) expr_chars.push_back(CH_OPEN);
				depth = opens;
			end
			repeat ($urandom_range(1, 24)) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					add_number();
				end else if (pick < 55) begin
					expr_chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
				end else if (pick < 72 && depth < max_depth) begin
					expr_chars.push_back(CH_OPEN);
					depth++;
				end else if (pick < 88 && (depth > 0 || broken)) begin
					expr_chars.push_back(CH_CLOSE);
					if (depth > 0)
						depth--;
				end else if (pick < 92) begin
					expr_chars.push_back(8'h20);
				end else begin
					add_number();
				end
			end
			// Close every open group unless the sequence is meant to be broken.
			if (!broken)
				repeat (depth) expr_chars.push_back(CH_CLOSE);
		end
	endtask

	task automatic run_random(input int unsigned min_chars, input int unsigned min_results);
		int unsigned start_chars, exprs;
		start_chars = char_count;
		exprs       = 0;
		while (char_count - start_chars < min_chars || exprs < min_results) begin
			build_expression();
			send_expression();
			exprs++;
		end
		wait_drain();
	endtask

	// Largest positive total plus one wraps to the most negative value.
	task automatic test_arithmetic_wrap();
		send_text("2147483647+1");
		wait_drain();
	endtask

	// Digits before '(' carry inside; the inner sign survives ')', so a
	// digit after the close is added with it.
	task automatic test_sign_carry();
		send_text("3(-2)5");
		wait_drain();
	endtask

	// Bytes other than digits, operators and parentheses are dropped.
	task automatic test_ignored_chars();
		expr_chars.push_back(8'hFF);
		expr_chars.push_back(8'h00);
		expr_chars.push_back(8'h20);
		expr_chars.push_back(8'h37);
		send_expression();
		wait_drain();
	endtask

	task automatic test_unmatched_close();
		send_text(")1");
		wait_drain();
	endtask

	// One open more than the stack holds.
	task automatic test_nest_overflow();
		repeat (NEST_LEVELS + 1) expr_chars.push_back(CH_OPEN);
		send_expression();
		wait_drain();
	endtask

	// Long stretch with neither side idling.
	task automatic test_back_to_back();
		send_idle_pct = 0;
		stall_pct     = 0;
		run_random(BURST_CHARS, 1);
	endtask

	task automatic test_random_mix();
		send_idle_pct = IDLE_PCT;
		stall_pct     = IDLE_PCT;
		run_random(RANDOM_CHARS, RANDOM_RESULTS);
	endtask

	initial begin
		clear_evaluation();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = IDLE_PCT;
		stall_pct     = IDLE_PCT;
		test_arithmetic_wrap();
		test_sign_carry();
		test_ignored_chars();
		test_unmatched_close();
		test_nest_overflow();
		test_back_to_back();
		test_random_mix();

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
